@@ sv/rfd_pkg.sv @@
// shared types, constants and decode tables for the rf remote frame decoder
package rfd_pkg;

    localparam int PulseW     = 16;
    localparam int CountW     = 6;
    localparam int FrameBitsW = 24;
    localparam int SysCodeW   = 20;
    localparam int NibW       = 4;
    localparam int CfgIndexW  = 2;

    localparam logic [CountW-1:0] LastPulseIdx = 6'd49;
    localparam logic [CountW-1:0] DataPulses   = 6'd48;
    localparam logic [CountW-1:0] CountMax     = 6'd63;

    localparam logic [PulseW-1:0] ThresholdReset = 16'd550;
    localparam logic [PulseW-1:0] FooterMinReset = 16'd6480;
    localparam logic [PulseW-1:0] FooterMaxReset = 16'd7920;

    // only the low nibble of the 0x13 type mask can hit a 4-bit nibble
    localparam logic [NibW-1:0] TypeMask = 4'h3;

    localparam int QueueDepth  = 2;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int QueueCountW = $clog2(QueueDepth + 1);

    typedef enum logic [CfgIndexW-1:0] {
        CFG_BIT_THRESHOLD = 2'd0,
        CFG_FOOTER_MIN    = 2'd1,
        CFG_FOOTER_MAX    = 2'd2
    } cfg_index_t;

    // one finished train on its way to the decoder
    typedef struct packed {
        logic                  ok;
        logic [FrameBitsW-1:0] bits;
    } frame_t;

    function automatic logic [NibW-1:0] hash_a(input logic [NibW-1:0] n);
        logic [NibW-1:0] r;
        case (n)
            4'h0: r = 4'h0;
            4'h1: r = 4'h9;
            4'h2: r = 4'hF;
            4'h3: r = 4'h4;
            4'h4: r = 4'hA;
            4'h5: r = 4'hD;
            4'h6: r = 4'h5;
            4'h7: r = 4'hB;
            4'h8: r = 4'h3;
            4'h9: r = 4'h2;
            4'hA: r = 4'h1;
            4'hB: r = 4'h7;
            4'hC: r = 4'hE;
            4'hD: r = 4'h6;
            4'hE: r = 4'hC;
            default: r = 4'h8;
        endcase
        return r;
    endfunction

    function automatic logic [NibW-1:0] hash_b(input logic [NibW-1:0] n);
        logic [NibW-1:0] r;
        case (n)
            4'h0: r = 4'h0;
            4'h1: r = 4'h9;
            4'h2: r = 4'h5;
            4'h3: r = 4'hF;
            4'h4: r = 4'h3;
            4'h5: r = 4'h6;
            4'h6: r = 4'hC;
            4'h7: r = 4'h7;
            4'h8: r = 4'hE;
            4'h9: r = 4'hD;
            4'hA: r = 4'h1;
            4'hB: r = 4'hB;
            4'hC: r = 4'h2;
            4'hD: r = 4'hA;
            4'hE: r = 4'h4;
            default: r = 4'h8;
        endcase
        return r;
    endfunction

    function automatic logic [NibW-1:0] hash_sel(input logic type_a, input logic [NibW-1:0] n);
        logic [NibW-1:0] r;
        r = type_a ? hash_a(n) : hash_b(n);
        return r;
    endfunction

    // state nibbles that mean "on", one mask per group of four units
    function automatic logic [15:0] on_set(input logic type_a, input logic [1:0] grp);
        logic [15:0] r;
        case ({type_a, grp})
            3'b100: r = 16'h0462;
            3'b101: r = 16'h0984;
            3'b110: r = 16'hC009;
            3'b111: r = 16'h3210;
            3'b000: r = 16'h0898;
            3'b001: r = 16'h0606;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

@@ sv/rfd_front.sv @@
// front end: config registers, pulse counting, bit slicing and frame check
module rfd_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rfd_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [rfd_pkg::PulseW-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [rfd_pkg::PulseW-1:0]     pulse_us,
    input  logic                           train_end,
    output logic                           push,
    output rfd_pkg::frame_t                push_frame
);
    import rfd_pkg::*;

    logic [PulseW-1:0]     threshold_reg, threshold_next;
    logic [PulseW-1:0]     footer_min_reg, footer_min_next;
    logic [PulseW-1:0]     footer_max_reg, footer_max_next;
    logic [CountW-1:0]     count_reg, count_next;
    logic [FrameBitsW-1:0] bits_reg, bits_next;
    logic                  accept;
    logic                  data_pulse;
    logic [FrameBitsW-1:0] bits_shifted;

    always_comb
    begin
        threshold_next  = threshold_reg;
        footer_min_next = footer_min_reg;
        footer_max_next = footer_max_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BIT_THRESHOLD: threshold_next  = cfg_data;
                CFG_FOOTER_MIN:    footer_min_next = cfg_data;
                CFG_FOOTER_MAX:    footer_max_next = cfg_data;
                default:           ;
            endcase
        end
    end

    assign accept     = in_valid && !in_stall;
    // odd pulses below 48 carry the data bits
    assign data_pulse = count_reg[0] && (count_reg < DataPulses);

    always_comb
    begin
        bits_shifted = bits_reg;
        if (data_pulse)
        begin
            bits_shifted = {bits_reg[FrameBitsW-2:0], (pulse_us <= threshold_reg)};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        bits_next  = bits_reg;
        if (accept)
        begin
            if (train_end)
            begin
                count_next = '0;
                bits_next  = '0;
            end
            else
            begin
                bits_next = bits_shifted;
                if (count_reg != CountMax)
                begin
                    count_next = count_reg + CountW'(1);
                end
            end
        end
    end

    assign push            = accept && train_end;
    assign push_frame.ok   = (count_reg == LastPulseIdx) && (pulse_us >= footer_min_reg)
                             && (pulse_us <= footer_max_reg);
    assign push_frame.bits = bits_shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= ThresholdReset;
            footer_min_reg <= FooterMinReset;
            footer_max_reg <= FooterMaxReset;
            count_reg      <= '0;
            bits_reg       <= '0;
        end
        else
        begin
            threshold_reg  <= threshold_next;
            footer_min_reg <= footer_min_next;
            footer_max_reg <= footer_max_next;
            count_reg      <= count_next;
            bits_reg       <= bits_next;
        end
    end

endmodule

@@ sv/rfd_queue.sv @@
// short frame queue between the front end and the decoder
module rfd_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rfd_pkg::frame_t push_frame,
    input  logic            pop,
    output logic            head_valid,
    output rfd_pkg::frame_t head_frame,
    output logic            full
);
    import rfd_pkg::*;

    frame_t                 mem_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueCountW-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QueueCountW'(QueueDepth));
    assign head_frame = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                          : wr_ptr_reg + QueuePtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                          : rd_ptr_reg + QueuePtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QueueCountW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QueueCountW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/rfd_back.sv @@
// back end: nibble decode and the registered result stage
module rfd_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  rfd_pkg::frame_t                 head_frame,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            frame_ok,
    output logic [rfd_pkg::SysCodeW-1:0]    system_code,
    output logic [rfd_pkg::NibW-1:0]        unit_number,
    output logic                            switch_on,
    output logic [rfd_pkg::FrameBitsW-1:0]  frame_bits
);
    import rfd_pkg::*;

    logic [NibW-1:0]       n1, n2, n3, n4, n5;
    logic [NibW-1:0]       d3, d4, d5;
    logic [NibW-1:0]       unit;
    logic                  type_a;
    logic [15:0]           on_mask;
    logic                  on;
    logic                  out_valid_reg, out_valid_next;
    logic                  ok_reg;
    logic [SysCodeW-1:0]   code_reg;
    logic [NibW-1:0]       unit_reg;
    logic                  on_reg;
    logic [FrameBitsW-1:0] bits_reg;

    // first received bit sits in the msb
    assign n1 = head_frame.bits[23:20];
    assign n2 = head_frame.bits[19:16];
    assign n3 = head_frame.bits[15:12];
    assign n4 = head_frame.bits[11:8];
    assign n5 = head_frame.bits[7:4];

    assign type_a = ((n1 & TypeMask) != '0);
    assign d3     = n3 ^ hash_sel(type_a, n2);
    assign d4     = n4 ^ hash_sel(type_a, n3);
    assign d5     = n5 ^ hash_sel(type_a, n4);

    // unit bits arrive lsb first
    assign unit    = {head_frame.bits[0], head_frame.bits[1],
                      head_frame.bits[2], head_frame.bits[3]};
    assign on_mask = on_set(type_a, unit[3:2]);
    assign on      = on_mask[n5];

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ok_reg   <= head_frame.ok;
            code_reg <= head_frame.ok ? {n1, 4'h0, d3, d4, d5} : '0;
            unit_reg <= head_frame.ok ? unit : '0;
            on_reg   <= head_frame.ok && on;
            bits_reg <= head_frame.ok ? head_frame.bits : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_ok    = ok_reg;
    assign system_code = code_reg;
    assign unit_number = unit_reg;
    assign switch_on   = on_reg;
    assign frame_bits  = bits_reg;

endmodule

@@ sv/rf_remote_frame_decoder.sv @@
// top level of the rf remote frame decoder
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | pulse_us, train_end
//  out     | output    | out_valid / out_stall| frame_ok, system_code, unit_number,
//          |           |                      | switch_on, frame_bits
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// one pulse request is taken every cycle while in_stall is low; a train_end request
// passes its result through a queue entry and the output register when the output is free
// in_stall rises only while the two-entry frame queue is full behind a stalled output
// reset clears the pulse counter, the collected bits, the queue and the output valid,
// and loads the three config registers with their defaults
module rf_remote_frame_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rfd_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [rfd_pkg::PulseW-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rfd_pkg::PulseW-1:0]      pulse_us,
    input  logic                            train_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            frame_ok,
    output logic [rfd_pkg::SysCodeW-1:0]    system_code,
    output logic [rfd_pkg::NibW-1:0]        unit_number,
    output logic                            switch_on,
    output logic [rfd_pkg::FrameBitsW-1:0]  frame_bits
);
    import rfd_pkg::*;

    logic   push;
    frame_t push_frame;
    logic   pop;
    logic   head_valid;
    frame_t head_frame;
    logic   q_full;

    assign in_stall = q_full;

    rfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (q_full),
        .pulse_us   (pulse_us),
        .train_end  (train_end),
        .push       (push),
        .push_frame (push_frame)
    );

    rfd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .full       (q_full)
    );

    rfd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_frame  (head_frame),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_ok    (frame_ok),
        .system_code (system_code),
        .unit_number (unit_number),
        .switch_on   (switch_on),
        .frame_bits  (frame_bits)
    );

`ifndef SYNTHESIS
    // a full queue only builds up behind a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("queue full without a pending result");

    // rejected frames carry all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_ok) |-> (system_code == '0 && unit_number == '0
                                      && !switch_on && frame_bits == '0))
        else $error("rejected frame with nonzero fields");

    // system code keeps the first nibble and a zero second nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_ok) |-> (system_code[19:16] == frame_bits[23:20]
                                     && system_code[15:12] == 4'h0))
        else $error("system code layout mismatch");

    // nothing reaches the queue while it is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !pop) |-> !push)
        else $error("push into full queue");
`endif

endmodule
